// File: design/trd_pkg.sv
// Shared types and constants for the TGA run-length image decoder.
package trd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PACKET,
    PH_PIXEL,
    PH_IDLE
  } phase_t;

  localparam logic [1:0] STATUS_PIXEL      = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIZE   = 2'd2;
  localparam logic [1:0] STATUS_BAD_DEPTH  = 2'd3;

  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_PREFIX_END = 5'd12;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;

  localparam logic [7:0] TYPE_RAW   = 8'h02;
  localparam logic [7:0] TYPE_RLE   = 8'h0A;
  localparam logic [7:0] DEPTH_24   = 8'd24;
  localparam logic [7:0] DEPTH_32   = 8'd32;
  localparam logic [7:0] COUNT_MASK = 8'h7F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic [1:0] status;
  } result_t;

endpackage

// File: design/trd_in_reg.sv
// Input register that holds one accepted byte until the parser takes it.
module trd_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  trd_pkg::item_t in_item,
  output logic           item_valid,
  output trd_pkg::item_t item,
  input  logic           item_take
);
  import trd_pkg::*;

  logic   valid;
  item_t  held;

  assign in_ready   = !valid || item_take;
  assign item_valid = valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_item;
    end
  end

endmodule

// File: design/trd_core.sv
// Header parser and pixel decoder state with its combinational next-state update.
module trd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  trd_pkg::item_t   item,
  output logic             item_take,
  input  logic             out_free,
  output logic             res_valid,
  output trd_pkg::result_t res
);
  import trd_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  header_index, header_index_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic        rle_mode, rle_mode_next;
  logic        four_byte_pixels, four_byte_pixels_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [23:0] pixel_bytes, pixel_bytes_next;

  phase_t      e_phase;
  logic [4:0]  e_hidx;
  logic [15:0] e_width, e_height;
  logic        e_rle, e_four, e_is_run;
  logic [31:0] e_pixels_left;
  logic [7:0]  e_packet_left;
  logic [1:0]  e_bip;
  logic [23:0] e_pbytes;

  logic [7:0]  b;
  logic        restart;
  logic        bad_prefix, dim_zero, depth_ok, hdr_error, hdr_done;
  logic [1:0]  hdr_code;
  logic [15:0] height_full;
  logic [31:0] area;
  logic        need_more;
  logic [7:0]  run_rep, rep, packet_after;
  logic [31:0] pixels_after;
  logic        pixel_out;

  assign b       = item.data_byte;
  assign restart = item.file_start;

  assign e_phase       = restart ? PH_HEADER : phase;
  assign e_hidx        = restart ? 5'd0 : header_index;
  assign e_width       = restart ? 16'd0 : image_width;
  assign e_height      = restart ? 16'd0 : image_height;
  assign e_rle         = restart ? 1'b0 : rle_mode;
  assign e_four        = restart ? 1'b0 : four_byte_pixels;
  assign e_pixels_left = restart ? 32'd0 : pixels_left;
  assign e_packet_left = restart ? 8'd0 : packet_left;
  assign e_is_run      = restart ? 1'b0 : packet_is_run;
  assign e_bip         = restart ? 2'd0 : byte_in_pixel;
  assign e_pbytes      = restart ? 24'd0 : pixel_bytes;

  assign bad_prefix = (e_hidx < HDR_PREFIX_END) &&
                      ((e_hidx == HDR_TYPE) ? (b != TYPE_RAW && b != TYPE_RLE)
                                            : (b != 8'd0));
  assign height_full = {b, e_height[7:0]};
  assign dim_zero    = (e_width == 16'd0) || (height_full == 16'd0);
  assign depth_ok    = (b == DEPTH_24) || (b == DEPTH_32);
  assign hdr_done    = (e_hidx >= HDR_LAST);
  assign area        = {16'd0, e_width} * {16'd0, e_height};

  always_comb begin
    hdr_code = STATUS_PIXEL;
    if (bad_prefix) begin
      hdr_code = STATUS_BAD_HEADER;
    end else if (e_hidx == HDR_HEIGHT_HI && dim_zero) begin
      hdr_code = STATUS_BAD_SIZE;
    end else if (e_hidx == HDR_DEPTH && !depth_ok) begin
      hdr_code = STATUS_BAD_DEPTH;
    end
  end
  assign hdr_error = (hdr_code != STATUS_PIXEL);

  assign need_more    = e_four ? (e_bip < 2'd3) : (e_bip < 2'd2);
  assign run_rep      = ({24'd0, e_packet_left} < e_pixels_left) ? e_packet_left
                                                                 : e_pixels_left[7:0];
  assign rep          = (e_rle && e_is_run) ? run_rep : 8'd1;
  assign pixels_after = e_pixels_left - {24'd0, rep};
  assign packet_after = e_rle ? (e_is_run ? 8'd0 : e_packet_left - 8'd1) : e_packet_left;
  assign pixel_out    = (e_phase == PH_PIXEL) && !need_more;

  assign res_valid = item_valid && (((e_phase == PH_HEADER) && hdr_error) || pixel_out);
  assign item_take = item_valid && (!res_valid || out_free);

  always_comb begin
    phase_next = e_phase;
    case (e_phase)
      PH_HEADER: begin
        if (hdr_error) begin
          phase_next = PH_IDLE;
        end else if (hdr_done) begin
          phase_next = e_rle ? PH_PACKET : PH_PIXEL;
        end
      end
      PH_PACKET: phase_next = PH_PIXEL;
      PH_PIXEL: begin
        if (!need_more) begin
          if (pixels_after == 32'd0) begin
            phase_next = PH_IDLE;
          end else if (e_rle && packet_after == 8'd0) begin
            phase_next = PH_PACKET;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    header_index_next     = e_hidx;
    image_width_next      = e_width;
    image_height_next     = e_height;
    rle_mode_next         = e_rle;
    four_byte_pixels_next = e_four;
    pixels_left_next      = e_pixels_left;
    packet_left_next      = e_packet_left;
    packet_is_run_next    = e_is_run;
    byte_in_pixel_next    = e_bip;
    pixel_bytes_next      = e_pbytes;
    res                   = '0;
    case (e_phase)
      PH_HEADER: begin
        if (e_hidx == HDR_TYPE) begin
          rle_mode_next = (b == TYPE_RLE);
        end
        if (e_hidx == HDR_WIDTH_LO) begin
          image_width_next = {8'd0, b};
        end
        if (e_hidx == HDR_WIDTH_HI) begin
          image_width_next = {b, e_width[7:0]};
        end
        if (e_hidx == HDR_HEIGHT_LO) begin
          image_height_next = {8'd0, b};
        end
        if (e_hidx == HDR_HEIGHT_HI) begin
          image_height_next = height_full;
        end
        if (e_hidx == HDR_DEPTH && depth_ok) begin
          four_byte_pixels_next = (b == DEPTH_32);
        end
        if (hdr_done) begin
          pixels_left_next   = area;
          byte_in_pixel_next = 2'd0;
          pixel_bytes_next   = 24'd0;
        end else if (!hdr_error) begin
          header_index_next = e_hidx + 5'd1;
        end
        res.status = hdr_code;
      end
      PH_PACKET: begin
        packet_left_next   = (b & COUNT_MASK) + 8'd1;
        packet_is_run_next = b[7];
        byte_in_pixel_next = 2'd0;
        pixel_bytes_next   = 24'd0;
      end
      PH_PIXEL: begin
        if (need_more) begin
          case (e_bip)
            2'd0:    pixel_bytes_next[7:0]   = b;
            2'd1:    pixel_bytes_next[15:8]  = b;
            default: pixel_bytes_next[23:16] = b;
          endcase
          byte_in_pixel_next = e_bip + 2'd1;
        end else begin
          pixels_left_next   = pixels_after;
          packet_left_next   = packet_after;
          byte_in_pixel_next = 2'd0;
          pixel_bytes_next   = 24'd0;
        end
        res.red          = e_four ? e_pbytes[23:16] : b;
        res.green        = e_pbytes[15:8];
        res.blue         = e_pbytes[7:0];
        res.alpha        = e_four ? b : 8'd0;
        res.has_alpha    = e_four;
        res.repeat_count = rep;
        res.last_pixel   = (pixels_after == 32'd0);
        res.status       = STATUS_PIXEL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_index     <= '0;
      image_width      <= '0;
      image_height     <= '0;
      rle_mode         <= 1'b0;
      four_byte_pixels <= 1'b0;
      pixels_left      <= '0;
      packet_left      <= '0;
      packet_is_run    <= 1'b0;
      byte_in_pixel    <= '0;
      pixel_bytes      <= '0;
    end else if (item_take) begin
      phase            <= phase_next;
      header_index     <= header_index_next;
      image_width      <= image_width_next;
      image_height     <= image_height_next;
      rle_mode         <= rle_mode_next;
      four_byte_pixels <= four_byte_pixels_next;
      pixels_left      <= pixels_left_next;
      packet_left      <= packet_left_next;
      packet_is_run    <= packet_is_run_next;
      byte_in_pixel    <= byte_in_pixel_next;
      pixel_bytes      <= pixel_bytes_next;
    end
  end

endmodule

// File: design/trd_out_reg.sv
// Result register that holds one decoded pixel or error until its transfer.
module trd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  trd_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output trd_pkg::result_t out_res
);
  import trd_pkg::*;

  logic    valid;
  result_t held;

  assign out_free  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      held <= res;
    end
  end

endmodule

// File: design/tga_rle_image_decoder.sv
// Top level of the TGA run-length image decoder.
// One byte is taken per cycle while no stalled result blocks it; a byte that yields a result
// shows it on the outputs after passing the input register, then the result register.
// The rate is set by the combinational parser state update between those registers.
// A result waiting on a stalled output blocks only a byte that would make another one.
// Synchronous reset empties both registers and returns the parser to header byte 0.
module tga_rle_image_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       file_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic       has_alpha,
  output logic [7:0] repeat_count,
  output logic       last_pixel,
  output logic [1:0] status
);
  import trd_pkg::*;

  item_t   in_item, item;
  logic    item_valid, item_take, out_free, res_valid;
  result_t res, out_res;

  assign in_item.data_byte  = data_byte;
  assign in_item.file_start = file_start;

  trd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  trd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  trd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign red          = out_res.red;
  assign green        = out_res.green;
  assign blue         = out_res.blue;
  assign alpha        = out_res.alpha;
  assign has_alpha    = out_res.has_alpha;
  assign repeat_count = out_res.repeat_count;
  assign last_pixel   = out_res.last_pixel;
  assign status       = out_res.status;

endmodule
